/* rtl/bmrf_pkg.sv */
// ----------------------------------------------------------------------------
// bmrf_pkg
// Shared constants, codes and types of the binary map rectangle finder.
// ----------------------------------------------------------------------------
`default_nettype none

package bmrf_pkg;

    // Map geometry
    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;

    // Derived widths
    localparam int ROW_W   = $clog2(MAX_ROWS);              // row index
    localparam int COL_W   = $clog2(MAX_COLS);              // column index
    localparam int RCNT_W  = $clog2(MAX_ROWS + 1);          // row count / height
    localparam int CCNT_W  = $clog2(MAX_COLS + 1);          // column count / width
    localparam int ADDR_W  = ROW_W + COL_W;                 // map memory address
    localparam int POS_W   = $clog2(MAX_ROWS * MAX_COLS + 1); // raster position
    localparam int STEP_W  = $clog2(POS_W + 1);             // divider step count

    // Fixed field widths
    localparam int CFG_W   = 7;
    localparam int CAT_W   = 2;
    localparam int AREA_W  = 13;

    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    // Record kinds, also the record slot index
    typedef enum logic [CAT_W-1:0] {
        CAT_WIDEST  = 2'd0,
        CAT_TALLEST = 2'd1,
        CAT_AREA    = 2'd2
    } t_cat;

    // Configuration register indexes
    typedef enum logic {
        CFG_ROWS = 1'b0,
        CFG_COLS = 1'b1
    } t_cfg_idx;

    // One rectangle record
    typedef struct packed {
        logic [ROW_W-1:0]  top_row;
        logic [COL_W-1:0]  left_col;
        logic [CCNT_W-1:0] width;
        logic [RCNT_W-1:0] height;
        logic [AREA_W-1:0] area;
    } t_rec;

    // Map memory write request
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic              data;
    } t_mem_wr;

    // Divider result and completion
    typedef struct packed {
        logic              done;
        logic [POS_W-1:0]  quo;
        logic [CCNT_W-1:0] rem;
    } t_div_res;

endpackage

`default_nettype wire

/* rtl/bmrf_cell_if.sv */
// ----------------------------------------------------------------------------
// bmrf_cell_if
// Input channel: one map cell per transfer, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface bmrf_cell_if;
    logic valid;
    logic ready;
    logic cell_req;

    modport source (output valid, output cell_req, input ready);
    modport sink   (input valid, input cell_req, output ready);
endinterface

`default_nettype wire

/* rtl/bmrf_rec_if.sv */
// ----------------------------------------------------------------------------
// bmrf_rec_if
// Output channel: one rectangle record per transfer, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface bmrf_rec_if;
    logic                          valid;
    logic                          ready;
    logic [bmrf_pkg::CAT_W-1:0]    category;
    logic [bmrf_pkg::ROW_W-1:0]    top_row;
    logic [bmrf_pkg::COL_W-1:0]    left_col;
    logic [bmrf_pkg::CCNT_W-1:0]   width;
    logic [bmrf_pkg::RCNT_W-1:0]   height;
    logic [bmrf_pkg::AREA_W-1:0]   area;
    logic                          last;

    modport source (output valid, output category, output top_row, output left_col,
                    output width, output height, output area, output last,
                    input ready);
    modport sink   (input valid, input category, input top_row, input left_col,
                    input width, input height, input area, input last,
                    output ready);
endinterface

`default_nettype wire

/* rtl/bmrf_map_ram.sv */
// ----------------------------------------------------------------------------
// bmrf_map_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module bmrf_map_ram #(
    parameter int ADDR_W = 12,
    parameter int DATA_W = 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output      logic [DATA_W-1:0] o_rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, old data on a same-address write
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/bmrf_div.sv */
// ----------------------------------------------------------------------------
// bmrf_div
// Restoring divider, one quotient bit per cycle: splits a raster position
// into row and column under the current column count.
// ----------------------------------------------------------------------------
`default_nettype none

module bmrf_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [bmrf_pkg::POS_W-1:0]  i_dividend,
    input  wire logic [bmrf_pkg::CCNT_W-1:0] i_divisor,
    output      bmrf_pkg::t_div_res          o_res
);

    logic                        r_busy;
    logic                        r_done;
    logic [bmrf_pkg::STEP_W-1:0] r_cnt;
    logic [bmrf_pkg::POS_W-1:0]  r_quo;
    logic [bmrf_pkg::CCNT_W-1:0] r_rem;

    logic [bmrf_pkg::CCNT_W:0]   trial;
    logic [bmrf_pkg::CCNT_W:0]   diff;
    logic                        ge;

    // Trial subtract of the divisor from the shifted partial remainder
    always_comb begin
        trial = {r_rem, r_quo[bmrf_pkg::POS_W-1]};
        ge    = (trial >= {1'b0, i_divisor});
        diff  = trial - {1'b0, i_divisor};
    end

    // Step sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= bmrf_pkg::STEP_W'(bmrf_pkg::POS_W);
                r_rem  <= '0;
                r_quo  <= i_dividend;
            end else if (r_busy) begin
                r_rem <= ge ? diff[bmrf_pkg::CCNT_W-1:0] : trial[bmrf_pkg::CCNT_W-1:0];
                r_quo <= {r_quo[bmrf_pkg::POS_W-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == bmrf_pkg::STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_res.done = r_done;
    assign o_res.quo  = r_quo;
    assign o_res.rem  = r_rem;

endmodule

`default_nettype wire

/* rtl/bmrf_scan.sv */
// ----------------------------------------------------------------------------
// bmrf_scan
// Scan sequencer: walks the map in raster order through the single map read
// port, traces and clears each rectangle, and keeps the three records.
// ----------------------------------------------------------------------------
`default_nettype none

module bmrf_scan (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [bmrf_pkg::RCNT_W-1:0] i_rows,
    input  wire logic [bmrf_pkg::CCNT_W-1:0] i_cols,
    input  wire logic                        i_rd_data,
    output      logic [bmrf_pkg::ADDR_W-1:0] o_rd_addr,
    output      bmrf_pkg::t_mem_wr           o_wr,
    output      logic                        o_done,
    output      bmrf_pkg::t_rec [2:0]        o_best
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CELL_RD,
        S_CELL_CK,
        S_WID_RD,
        S_WID_CK,
        S_HGT_START,
        S_HGT_RD,
        S_HGT_CK,
        S_CLR,
        S_AREA,
        S_REC,
        S_ADV,
        S_DONE
    } t_state;

    t_state                      r_state, n_state;
    logic [bmrf_pkg::RCNT_W-1:0] r_r,  n_r;     // scan row / top row
    logic [bmrf_pkg::CCNT_W-1:0] r_c,  n_c;     // scan column / left column
    logic [bmrf_pkg::CCNT_W-1:0] r_k,  n_k;     // walk column
    logic [bmrf_pkg::RCNT_W-1:0] r_rr, n_rr;    // walk row
    logic [bmrf_pkg::CCNT_W-1:0] r_w,  n_w;
    logic [bmrf_pkg::RCNT_W-1:0] r_h,  n_h;
    logic [bmrf_pkg::AREA_W-1:0] r_area, n_area;
    bmrf_pkg::t_rec [2:0]        r_best, n_best;

    logic [bmrf_pkg::RCNT_W+bmrf_pkg::CCNT_W-1:0] area_full;
    bmrf_pkg::t_rec                               cand;

    assign area_full = r_w * r_h;

    // Candidate record of the rectangle just traced
    always_comb begin
        cand.top_row  = r_r[bmrf_pkg::ROW_W-1:0];
        cand.left_col = r_c[bmrf_pkg::COL_W-1:0];
        cand.width    = r_w;
        cand.height   = r_h;
        cand.area     = r_area;
    end

    // Next state, memory port control
    always_comb begin
        n_state   = r_state;
        n_r       = r_r;
        n_c       = r_c;
        n_k       = r_k;
        n_rr      = r_rr;
        n_w       = r_w;
        n_h       = r_h;
        n_area    = r_area;
        n_best    = r_best;
        o_rd_addr = {r_r[bmrf_pkg::ROW_W-1:0], r_c[bmrf_pkg::COL_W-1:0]};
        o_wr.en   = 1'b0;
        o_wr.addr = {r_rr[bmrf_pkg::ROW_W-1:0], r_k[bmrf_pkg::COL_W-1:0]};
        o_wr.data = 1'b0;
        o_done    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
            end
            S_CELL_RD: begin
                n_state = S_CELL_CK;
            end
            S_CELL_CK: begin
                if (i_rd_data) begin
                    n_k     = r_c;
                    n_w     = '0;
                    n_state = S_WID_RD;
                end else begin
                    n_state = S_ADV;
                end
            end
            // width: run of set cells along the top row, cleared as we go
            S_WID_RD: begin
                o_rd_addr = {r_r[bmrf_pkg::ROW_W-1:0], r_k[bmrf_pkg::COL_W-1:0]};
                n_state   = S_WID_CK;
            end
            S_WID_CK: begin
                if (i_rd_data) begin
                    o_wr.en   = 1'b1;
                    o_wr.addr = {r_r[bmrf_pkg::ROW_W-1:0], r_k[bmrf_pkg::COL_W-1:0]};
                    n_w       = r_w + 1'b1;
                    n_k       = r_k + 1'b1;
                    n_state   = ((r_k + 1'b1) < i_cols) ? S_WID_RD : S_HGT_START;
                end else begin
                    n_state = S_HGT_START;
                end
            end
            // height: rows below whose left-column cell is set
            S_HGT_START: begin
                n_h     = bmrf_pkg::RCNT_W'(1);
                n_rr    = r_r + 1'b1;
                n_state = ((r_r + 1'b1) < i_rows) ? S_HGT_RD : S_AREA;
            end
            S_HGT_RD: begin
                o_rd_addr = {r_rr[bmrf_pkg::ROW_W-1:0], r_c[bmrf_pkg::COL_W-1:0]};
                n_state   = S_HGT_CK;
            end
            S_HGT_CK: begin
                if (i_rd_data) begin
                    n_h     = r_h + 1'b1;
                    n_k     = r_c;
                    n_state = S_CLR;
                end else begin
                    n_state = S_AREA;
                end
            end
            // clear the rectangle's span in this row, one cell a cycle
            S_CLR: begin
                o_wr.en = 1'b1;
                if ((r_k + 1'b1) == (r_c + r_w)) begin
                    n_rr    = r_rr + 1'b1;
                    n_state = ((r_rr + 1'b1) < i_rows) ? S_HGT_RD : S_AREA;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_AREA: begin
                n_area  = area_full[bmrf_pkg::AREA_W-1:0];
                n_state = S_REC;
            end
            // strictly greater replaces, ties keep the first
            S_REC: begin
                if (r_w > r_best[bmrf_pkg::CAT_WIDEST].width) begin
                    n_best[bmrf_pkg::CAT_WIDEST] = cand;
                end
                if (r_h > r_best[bmrf_pkg::CAT_TALLEST].height) begin
                    n_best[bmrf_pkg::CAT_TALLEST] = cand;
                end
                if (r_area > r_best[bmrf_pkg::CAT_AREA].area) begin
                    n_best[bmrf_pkg::CAT_AREA] = cand;
                end
                n_state = S_ADV;
            end
            S_ADV: begin
                if ((r_c + 1'b1) == i_cols) begin
                    n_c = '0;
                    if ((r_r + 1'b1) == i_rows) begin
                        n_state = S_DONE;
                    end else begin
                        n_r     = r_r + 1'b1;
                        n_state = S_CELL_RD;
                    end
                end else begin
                    n_c     = r_c + 1'b1;
                    n_state = S_CELL_RD;
                end
            end
            S_DONE: begin
                o_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // a start restarts the scan with cleared records
        if (i_start) begin
            n_r     = '0;
            n_c     = '0;
            n_best  = '0;
            n_state = S_CELL_RD;
        end
    end

    // State and records
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_r     <= '0;
            r_c     <= '0;
            r_best  <= '0;
        end else begin
            r_state <= n_state;
            r_r     <= n_r;
            r_c     <= n_c;
            r_best  <= n_best;
        end
        r_k    <= n_k;
        r_rr   <= n_rr;
        r_w    <= n_w;
        r_h    <= n_h;
        r_area <= n_area;
    end

    assign o_best = r_best;

    // Map writes only clear cells during tracing
    a_wr_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr.en |-> (r_state == S_WID_CK || r_state == S_CLR))
        else $error("map write outside tracing");

    // Largest area never shrinks within a scan
    a_area_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_start |=> r_best[bmrf_pkg::CAT_AREA].area >= $past(r_best[bmrf_pkg::CAT_AREA].area))
        else $error("area record decreased");

    // Done is a single-cycle pulse
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("done held longer than one cycle");

endmodule

`default_nettype wire

/* rtl/binary_map_rectangle_finder.sv */
// ----------------------------------------------------------------------------
// binary_map_rectangle_finder
// Loads a binary map cell by cell, scans it for rectangles and returns the
// widest, tallest and largest-area rectangle records.
// ----------------------------------------------------------------------------
// Usage:
//   i_cell takes map cells in raster order, one per transfer, at most one per
//   cycle while loading. row_count and col_count come in over the write port
//   (index 0 and 1); 0 counts as 1 and values above 64 as 64.
//   A register write while loading re-splits the raster position into row and
//   column with the bit-serial divider; ready stays low until it is done.
//   The transfer of the last cell starts the scan. The scan reads the map
//   memory one cell per step, since the map memory has a single read port.
//   Then o_rec presents three records (widest, tallest, largest area; last
//   on the third). While the scan runs and records wait, i_cell is not
//   ready; a stalled o_rec simply holds its record.
//   After the third record transfers, a new map loads from position zero;
//   records clear when the next scan starts. Reset sets both counts to 64 and
//   starts loading at zero; there is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_map_rectangle_finder (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    bmrf_cell_if.sink                       i_cell,
    bmrf_rec_if.source                      o_rec,
    input  wire logic                       i_cfg_we,
    input  wire logic                       i_cfg_idx,
    input  wire logic [bmrf_pkg::CFG_W-1:0] i_cfg_data
);

    typedef enum logic [2:0] {
        T_LOAD,
        T_REMAP,
        T_DIV,
        T_SCAN,
        T_OUT
    } t_state;

    t_state                      r_state, n_state;
    logic [bmrf_pkg::CFG_W-1:0]  r_rows_cfg, n_rows_cfg;
    logic [bmrf_pkg::CFG_W-1:0]  r_cols_cfg, n_cols_cfg;
    logic [bmrf_pkg::POS_W-1:0]  r_total;
    logic [bmrf_pkg::POS_W-1:0]  r_pos, n_pos;
    logic [bmrf_pkg::RCNT_W-1:0] r_ld_row, n_ld_row;
    logic [bmrf_pkg::CCNT_W-1:0] r_ld_col, n_ld_col;
    logic [bmrf_pkg::CAT_W-1:0]  r_k, n_k;

    logic [bmrf_pkg::RCNT_W-1:0] eff_rows;
    logic [bmrf_pkg::CCNT_W-1:0] eff_cols;
    logic [bmrf_pkg::RCNT_W+bmrf_pkg::CCNT_W-1:0] total_full;

    logic                        cell_xfer;
    logic                        ld_we;
    logic                        scan_start;
    logic                        div_start;
    bmrf_pkg::t_div_res          div_res;

    logic [bmrf_pkg::ADDR_W-1:0] scan_rd_addr;
    bmrf_pkg::t_mem_wr           scan_wr;
    logic                        scan_done;
    bmrf_pkg::t_rec [2:0]        best;
    bmrf_pkg::t_rec              sel_rec;

    logic                        ram_we;
    logic [bmrf_pkg::ADDR_W-1:0] ram_waddr;
    logic                        ram_wdata;
    logic                        ram_rdata;

    // Effective map size
    always_comb begin
        if (r_rows_cfg == '0) begin
            eff_rows = bmrf_pkg::RCNT_W'(1);
        end else if (r_rows_cfg > bmrf_pkg::CFG_W'(bmrf_pkg::MAX_ROWS)) begin
            eff_rows = bmrf_pkg::RCNT_W'(bmrf_pkg::MAX_ROWS);
        end else begin
            eff_rows = bmrf_pkg::RCNT_W'(r_rows_cfg);
        end
        if (r_cols_cfg == '0) begin
            eff_cols = bmrf_pkg::CCNT_W'(1);
        end else if (r_cols_cfg > bmrf_pkg::CFG_W'(bmrf_pkg::MAX_COLS)) begin
            eff_cols = bmrf_pkg::CCNT_W'(bmrf_pkg::MAX_COLS);
        end else begin
            eff_cols = bmrf_pkg::CCNT_W'(r_cols_cfg);
        end
    end

    assign total_full = eff_rows * eff_cols;

    // Handshakes
    assign i_cell.ready = (r_state == T_LOAD);
    assign cell_xfer    = i_cell.valid && i_cell.ready;
    assign ld_we        = cell_xfer && (r_pos < r_total);

    // Load, remap and output sequencing
    always_comb begin
        n_state    = r_state;
        n_rows_cfg = r_rows_cfg;
        n_cols_cfg = r_cols_cfg;
        n_pos      = r_pos;
        n_ld_row   = r_ld_row;
        n_ld_col   = r_ld_col;
        n_k        = r_k;
        scan_start = 1'b0;
        div_start  = 1'b0;

        // register writes
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bmrf_pkg::CFG_ROWS: n_rows_cfg = i_cfg_data;
                bmrf_pkg::CFG_COLS: n_cols_cfg = i_cfg_data;
                default:            n_rows_cfg = r_rows_cfg;
            endcase
        end

        unique case (r_state)
            T_LOAD: begin
                if (cell_xfer) begin
                    n_pos = r_pos + 1'b1;
                    if (ld_we) begin
                        if ((r_ld_col + 1'b1) == eff_cols) begin
                            n_ld_col = '0;
                            n_ld_row = r_ld_row + 1'b1;
                        end else begin
                            n_ld_col = r_ld_col + 1'b1;
                        end
                    end
                    if ((r_pos + 1'b1) >= r_total) begin
                        scan_start = 1'b1;
                        n_state    = T_SCAN;
                    end
                end
            end
            T_REMAP: begin
                div_start = 1'b1;
                n_state   = T_DIV;
            end
            T_DIV: begin
                if (div_res.done) begin
                    n_ld_row = div_res.quo[bmrf_pkg::RCNT_W-1:0];
                    n_ld_col = div_res.rem;
                    n_state  = T_LOAD;
                end
            end
            T_SCAN: begin
                if (scan_done) begin
                    n_k     = bmrf_pkg::CAT_WIDEST;
                    n_state = T_OUT;
                end
            end
            T_OUT: begin
                if (o_rec.ready) begin
                    if (r_k == bmrf_pkg::CAT_AREA) begin
                        n_pos    = '0;
                        n_ld_row = '0;
                        n_ld_col = '0;
                        n_state  = T_LOAD;
                    end else begin
                        n_k = r_k + 1'b1;
                    end
                end
            end
            default: begin
                n_state = T_LOAD;
            end
        endcase

        // a size change re-splits the load position
        if (i_cfg_we && (n_state inside {T_LOAD, T_REMAP, T_DIV})) begin
            n_state = T_REMAP;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= T_LOAD;
            r_rows_cfg <= bmrf_pkg::CFG_RESET;
            r_cols_cfg <= bmrf_pkg::CFG_RESET;
            r_total    <= bmrf_pkg::POS_W'(bmrf_pkg::MAX_ROWS * bmrf_pkg::MAX_COLS);
            r_pos      <= '0;
            r_ld_row   <= '0;
            r_ld_col   <= '0;
            r_k        <= '0;
        end else begin
            r_state    <= n_state;
            r_rows_cfg <= n_rows_cfg;
            r_cols_cfg <= n_cols_cfg;
            r_total    <= total_full[bmrf_pkg::POS_W-1:0];
            r_pos      <= n_pos;
            r_ld_row   <= n_ld_row;
            r_ld_col   <= n_ld_col;
            r_k        <= n_k;
        end
    end

    // Position to row/column divider
    bmrf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_pos),
        .i_divisor  (eff_cols),
        .o_res      (div_res)
    );

    // Scan sequencer
    bmrf_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (scan_start),
        .i_rows    (eff_rows),
        .i_cols    (eff_cols),
        .i_rd_data (ram_rdata),
        .o_rd_addr (scan_rd_addr),
        .o_wr      (scan_wr),
        .o_done    (scan_done),
        .o_best    (best)
    );

    // Map memory write port: loader while loading, scanner otherwise
    always_comb begin
        if (r_state == T_LOAD) begin
            ram_we    = ld_we;
            ram_waddr = {r_ld_row[bmrf_pkg::ROW_W-1:0], r_ld_col[bmrf_pkg::COL_W-1:0]};
            ram_wdata = i_cell.cell_req;
        end else begin
            ram_we    = scan_wr.en;
            ram_waddr = scan_wr.addr;
            ram_wdata = scan_wr.data;
        end
    end

    bmrf_map_ram #(
        .ADDR_W (bmrf_pkg::ADDR_W),
        .DATA_W (1)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (scan_rd_addr),
        .o_rdata (ram_rdata)
    );

    // Record select for the output channel
    always_comb begin
        case (r_k)
            bmrf_pkg::CAT_WIDEST:  sel_rec = best[bmrf_pkg::CAT_WIDEST];
            bmrf_pkg::CAT_TALLEST: sel_rec = best[bmrf_pkg::CAT_TALLEST];
            bmrf_pkg::CAT_AREA:    sel_rec = best[bmrf_pkg::CAT_AREA];
            default:               sel_rec = '0;
        endcase
    end

    assign o_rec.valid    = (r_state == T_OUT);
    assign o_rec.category = r_k;
    assign o_rec.top_row  = sel_rec.top_row;
    assign o_rec.left_col = sel_rec.left_col;
    assign o_rec.width    = sel_rec.width;
    assign o_rec.height   = sel_rec.height;
    assign o_rec.area     = sel_rec.area;
    assign o_rec.last     = (r_k == bmrf_pkg::CAT_AREA);

    // Loading and record output never overlap
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_rec.valid && i_cell.ready))
        else $error("cell ready while a record is pending");

    // The final record is always the area record
    a_last_cat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rec.valid && o_rec.last) |-> (o_rec.category == bmrf_pkg::CAT_AREA))
        else $error("last flag on a non-area record");

    // A new map starts at position zero after the final transfer
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rec.valid && o_rec.ready && o_rec.last) |=> (r_pos == '0))
        else $error("load position not reset after records");

endmodule

`default_nettype wire
